@@ src/spq_pkg.sv @@
// shared types and constants for the stable priority queue
`default_nettype none
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [15:0] id;
    logic        kind;
    logic [15:0] tag;
    logic [15:0] amount;
    logic [7:0]  prio;
  } entry_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ src/spq_cell.sv @@
// one slot of the sorted chain: holds an entry and shifts with its neighbors
`default_nettype none
module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_cmd_t cmd,
  input  wire logic               occ,
  input  wire logic               left_ge,
  input  wire spq_pkg::entry_t    left_ent,
  input  wire spq_pkg::entry_t    right_ent,
  output logic                    ge,
  output spq_pkg::entry_t         ent
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // new entry goes before this slot when the slot is free or holds a larger value
  assign ge  = !occ || (ent_r.prio > cmd.ent.prio);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    priority if (cmd.ins) begin
      if (ge) begin
        ent_nxt = left_ge ? left_ent : cmd.ent;
      end
    end else if (cmd.rem) begin
      ent_nxt = right_ent;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

@@ src/stable_priority_queue_core.sv @@
// top level of the stable priority queue: command decode, fill count and cell chain
// a result is registered and shows on the out_ ports in the cycle after its transaction is taken
// throughput: one insert or remove every cycle, every cell of the chain updates at once
// busy is high only while rst_n is low, so start is taken on any cycle after reset
// reset: synchronous active-low rst_n empties the queue and clears out_valid
// slot contents are not cleared, only slots below the fill count are ever read
`default_nettype none
module stable_priority_queue_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [15:0] in_req_id,
  input  wire logic        in_req_kind,
  input  wire logic [15:0] in_receiver_tag,
  input  wire logic [15:0] in_amount,
  input  wire logic [7:0]  in_prio,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [15:0]      out_id,
  output logic             out_kind,
  output logic [15:0]      out_receiver,
  output logic [15:0]      out_amount,
  output logic [7:0]       out_prio,
  output logic [4:0]       out_occupancy
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             valid_r;
  status_t          status_r;
  status_t          status_nxt;
  entry_t           res_r;
  entry_t           res_nxt;
  logic [4:0]       occ_r;

  cell_cmd_t        cmd;
  logic             take;
  logic             full;
  logic             empty;
  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] ge;
  entry_t           ents [DEPTH];

  assign busy  = !rst_n;
  assign take  = start && !busy;
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    cmd.ent.id     = in_req_id;
    cmd.ent.kind   = in_req_kind;
    cmd.ent.tag    = in_receiver_tag;
    cmd.ent.amount = in_amount;
    cmd.ent.prio   = in_prio;
    cmd.ins        = take && !in_func && !full;
    cmd.rem        = take && in_func && !empty;
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign occ[g] = (CNT_W'(g) < count_r);
      if (g == 0) begin : g_first
        spq_cell u_cell (
          .clk       (clk),
          .cmd       (cmd),
          .occ       (occ[g]),
          .left_ge   (1'b0),
          .left_ent  (cmd.ent),
          .right_ent ((DEPTH > 1) ? ents[(g + 1) % DEPTH] : cmd.ent),
          .ge        (ge[g]),
          .ent       (ents[g])
        );
      end else if (g == DEPTH - 1) begin : g_last
        spq_cell u_cell (
          .clk       (clk),
          .cmd       (cmd),
          .occ       (occ[g]),
          .left_ge   (ge[g-1]),
          .left_ent  (ents[g-1]),
          .right_ent (cmd.ent),
          .ge        (ge[g]),
          .ent       (ents[g])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk       (clk),
          .cmd       (cmd),
          .occ       (occ[g]),
          .left_ge   (ge[g-1]),
          .left_ent  (ents[g-1]),
          .right_ent (ents[g+1]),
          .ge        (ge[g]),
          .ent       (ents[g])
        );
      end
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_INSERTED;
    res_nxt    = '0;
    if (in_func) begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_REMOVED;
        res_nxt    = ents[0];
        count_nxt  = count_r - CNT_W'(1);
      end
    end else begin
      if (full) begin
        status_nxt = ST_DROPPED;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
      if (take) begin
        count_r <= count_nxt;
      end
    end
    if (take) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      occ_r    <= 5'(count_nxt);
    end
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_id        = res_r.id;
  assign out_kind      = res_r.kind;
  assign out_receiver  = res_r.tag;
  assign out_amount    = res_r.amount;
  assign out_prio      = res_r.prio;
  assign out_occupancy = occ_r;

endmodule
`default_nettype wire

@@ src/spq_checker.sv @@
// port-level checks for the stable priority queue, bound to the top level
`default_nettype none
module spq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_id,
  input wire logic        out_kind,
  input wire logic [15:0] out_receiver,
  input wire logic [15:0] out_amount,
  input wire logic [7:0]  out_prio,
  input wire logic [4:0]  out_occupancy
);
  import spq_pkg::*;

  // every transaction gives a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("no result after accepted transaction");

  // no result without a transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without transaction");

  // payload fields are zero unless an entry was removed
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_REMOVED) |->
      (out_id == '0 && out_kind == 1'b0 && out_receiver == '0 &&
       out_amount == '0 && out_prio == '0))
    else $error("payload not zero on non-removal result");

  // empty report only with nothing stored
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_occupancy == '0))
    else $error("empty status with nonzero occupancy");

  // dropped insert only when full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DROPPED) |-> (out_occupancy == 5'(DEPTH)))
    else $error("dropped insert while not full");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_status    (out_status),
  .out_id        (out_id),
  .out_kind      (out_kind),
  .out_receiver  (out_receiver),
  .out_amount    (out_amount),
  .out_prio      (out_prio),
  .out_occupancy (out_occupancy)
);
`default_nettype wire

@@ tb/stable_priority_queue_core_test.sv @@
// self-checking testbench for the stable priority queue core
`timescale 1ns / 1ps
module stable_priority_queue_core_test;
  import spq_pkg::*;

  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_REMOVE = 1'b1;
  localparam int RANDOM_ITEMS = 630;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_CAP = 50;
  localparam entry_t ENT_ZERO = '0;
  localparam entry_t ENT_ONES = '1;

  typedef struct packed {
    status_t    status;
    entry_t     ent;
    logic [4:0] occ;
  } outcome_t;

  typedef struct {
    logic     func;
    entry_t   ent;
    logic     pinned;
    outcome_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_func;
  logic [15:0] in_req_id;
  logic        in_req_kind;
  logic [15:0] in_receiver_tag;
  logic [15:0] in_amount;
  logic [7:0]  in_prio;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_id;
  logic        out_kind;
  logic [15:0] out_receiver;
  logic [15:0] out_amount;
  logic [7:0]  out_prio;
  logic [4:0]  out_occupancy;

  stable_priority_queue_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_req_id       (in_req_id),
    .in_req_kind     (in_req_kind),
    .in_receiver_tag (in_receiver_tag),
    .in_amount       (in_amount),
    .in_prio         (in_prio),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_kind        (out_kind),
    .out_receiver    (out_receiver),
    .out_amount      (out_amount),
    .out_prio        (out_prio),
    .out_occupancy   (out_occupancy)
  );

  entry_t    shadow_queue[$];
  outcome_t  pending_results[$];
  stim_row_t directed_rows[$];

  logic     row_pinned;
  outcome_t row_want;
  int       mismatch_count;
  int       quiet_cycles;
  int       accepted_count;
  int       inserted_count;
  int       removed_count;
  int       empty_count;
  int       dropped_count;
  int       peak_occ;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // sorted insert behind equal priorities, removal from the front
  function automatic outcome_t queue_step(logic fn, entry_t ent);
    outcome_t res;
    int pos;
    res = '0;
    if (fn == FN_INSERT) begin
      if (shadow_queue.size() >= DEPTH) begin
        res.status = ST_DROPPED;
      end else begin
        pos = 0;
        while (pos < shadow_queue.size() && shadow_queue[pos].prio <= ent.prio) pos++;
        shadow_queue.insert(pos, ent);
        res.status = ST_INSERTED;
      end
    end else if (shadow_queue.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.status = ST_REMOVED;
      res.ent = shadow_queue.pop_front();
    end
    res.occ = 5'(shadow_queue.size());
    return res;
  endfunction

  function automatic stim_row_t mk_row(logic fn, entry_t ent, logic pinned = 1'b0,
                                       status_t st = ST_INSERTED, entry_t got = '0,
                                       logic [4:0] occ = '0);
    stim_row_t r;
    r.func = fn;
    r.ent = ent;
    r.pinned = pinned;
    r.want.status = st;
    r.want.ent = got;
    r.want.occ = occ;
    return r;
  endfunction

  function automatic entry_t mk_entry(logic [15:0] id, logic kind, logic [7:0] pr);
    entry_t e;
    e.id = id;
    e.kind = kind;
    e.tag = 16'h1000 + id;
    e.amount = 16'h0100 * id;
    e.prio = pr;
    return e;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t predicted;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending, status", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_id !== want.ent.id) report_mismatch("id", out_id, want.ent.id);
        if (out_kind !== want.ent.kind) report_mismatch("kind", out_kind, want.ent.kind);
        if (out_receiver !== want.ent.tag)
          report_mismatch("receiver", out_receiver, want.ent.tag);
        if (out_amount !== want.ent.amount)
          report_mismatch("amount", out_amount, want.ent.amount);
        if (out_prio !== want.ent.prio) report_mismatch("prio", out_prio, want.ent.prio);
        if (out_occupancy !== want.occ)
          report_mismatch("occupancy", out_occupancy, want.occ);
        case (want.status)
          ST_INSERTED: inserted_count++;
          ST_REMOVED:  removed_count++;
          ST_EMPTY:    empty_count++;
          default:     dropped_count++;
        endcase
        if (want.occ > peak_occ) peak_occ = want.occ;
      end
    end
    // check before predicting: a result shows in the cycle after its transaction
    if (rst_n && start && !busy) begin
      predicted = queue_step(in_func, entry_t'({in_req_id, in_req_kind, in_receiver_tag,
                                                in_amount, in_prio}));
      pending_results.push_back(row_pinned ? row_want : predicted);
      accepted_count++;
    end
    if ((rst_n && start && !busy) || out_valid) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("stable_priority_queue_core_test failed");
    $finish;
  end

  task automatic issue_request(logic fn, entry_t ent, logic pinned, outcome_t want);
    @(negedge clk);
    start = 1'b1;
    in_func = fn;
    {in_req_id, in_req_kind, in_receiver_tag, in_amount, in_prio} = ent;
    row_pinned = pinned;
    row_want = want;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start = 1'b0;
    in_func = $urandom_range(1);
    {in_req_id, in_req_kind, in_receiver_tag, in_amount, in_prio} =
      {$urandom, $urandom};
    row_pinned = 1'b0;
  endtask

  task automatic run_phase(int n_items, int idle_pct);
    int mode;
    int left;
    int ins_pct;
    entry_t ent;
    logic fn;
    while (n_items > 0) begin
      mode = $urandom_range(5);
      left = $urandom_range(4, 24);
      // fill and drain bursts run past the bounds to hit full and empty
      if (mode >= 4) left = DEPTH + $urandom_range(1, 3);
      case (mode)
        0: ins_pct = 75;
        1: ins_pct = 25;
        2: ins_pct = 50;
        3: ins_pct = 60;
        4: ins_pct = 100;
        default: ins_pct = 0;
      endcase
      while (left > 0 && n_items > 0) begin
        while ($urandom_range(99) < idle_pct) idle_cycle();
        fn = ($urandom_range(99) < ins_pct) ? FN_INSERT : FN_REMOVE;
        ent = {$urandom, $urandom};
        case ($urandom_range(3))
          0: ent.prio = $urandom_range(3);
          1: ent.prio = $urandom_range(15);
          2: ent.prio = $urandom_range(1) ? 8'hFF : 8'h00;
          default: ent.prio = $urandom;
        endcase
        issue_request(fn, ent, 1'b0, '0);
        left--;
        n_items--;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FN_INSERT;
    in_req_id = '0;
    in_req_kind = 1'b0;
    in_receiver_tag = '0;
    in_amount = '0;
    in_prio = '0;
    row_pinned = 1'b0;
    row_want = '0;
    mismatch_count = 0;
    quiet_cycles = 0;
    accepted_count = 0;
    inserted_count = 0;
    removed_count = 0;
    empty_count = 0;
    dropped_count = 0;
    peak_occ = 0;

    // extremes and empty queue, removes drive their ignored fields with all ones or all zeros
    directed_rows.push_back(mk_row(FN_REMOVE, ENT_ONES, 1'b1, ST_EMPTY, ENT_ZERO, 5'd0));
    directed_rows.push_back(mk_row(FN_INSERT, ENT_ONES, 1'b1, ST_INSERTED, ENT_ZERO, 5'd1));
    directed_rows.push_back(mk_row(FN_INSERT, ENT_ZERO, 1'b1, ST_INSERTED, ENT_ZERO, 5'd2));
    directed_rows.push_back(mk_row(FN_REMOVE, ENT_ONES, 1'b1, ST_REMOVED, ENT_ZERO, 5'd1));
    directed_rows.push_back(mk_row(FN_REMOVE, ENT_ZERO, 1'b1, ST_REMOVED, ENT_ONES, 5'd0));
    directed_rows.push_back(mk_row(FN_REMOVE, ENT_ONES, 1'b1, ST_EMPTY, ENT_ZERO, 5'd0));
    // equal priorities must leave in arrival order
    directed_rows.push_back(mk_row(FN_INSERT, mk_entry(16'd1, 1'b0, 8'd5)));
    directed_rows.push_back(mk_row(FN_INSERT, mk_entry(16'd2, 1'b1, 8'd5)));
    directed_rows.push_back(mk_row(FN_INSERT, mk_entry(16'd3, 1'b0, 8'd3)));
    directed_rows.push_back(mk_row(FN_INSERT, mk_entry(16'd4, 1'b1, 8'd5)));
    directed_rows.push_back(mk_row(FN_INSERT, mk_entry(16'd5, 1'b0, 8'd255)));
    directed_rows.push_back(mk_row(FN_INSERT, mk_entry(16'd6, 1'b1, 8'd0)));
    for (int k = 0; k < 6; k++)
      directed_rows.push_back(mk_row(FN_REMOVE, mk_entry(16'(k * 16'h1357), k[0], 8'hA5)));
    directed_rows.push_back(mk_row(FN_REMOVE, ENT_ZERO, 1'b1, ST_EMPTY, ENT_ZERO, 5'd0));
    // alternating bit patterns
    directed_rows.push_back(mk_row(FN_INSERT, {16'hAAAA, 1'b1, 16'h5555, 16'hAAAA, 8'hAA}));
    directed_rows.push_back(mk_row(FN_INSERT, {16'h5555, 1'b0, 16'hAAAA, 16'h5555, 8'h55}));
    directed_rows.push_back(mk_row(FN_REMOVE, ENT_ZERO));
    directed_rows.push_back(mk_row(FN_REMOVE, ENT_ZERO));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r])
      issue_request(directed_rows[r].func, directed_rows[r].ent, directed_rows[r].pinned,
                    directed_rows[r].want);
    run_phase(RANDOM_ITEMS / 3, 0);
    run_phase(RANDOM_ITEMS / 3, 78);
    run_phase(RANDOM_ITEMS / 3, 31);
    @(negedge clk);
    start = 1'b0;
    row_pinned = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("ran %0d requests: %0d inserts, %0d removals, %0d removes on empty, %0d drops",
             accepted_count, inserted_count, removed_count, empty_count, dropped_count);
    $display("highest occupancy reached %0d of %0d, %0d mismatches",
             peak_occ, DEPTH, mismatch_count);
    if (mismatch_count == 0) begin
      $display("stable_priority_queue_core_test passed");
    end else begin
      $display("stable_priority_queue_core_test failed");
    end
    $finish;
  end

endmodule
